// ===== rtl/core/preemptive_priority_scheduler_defines.svh =====
// assertion macros for the preemptive priority scheduler
// no dependencies; taken in by files that carry concurrent assertions
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define PPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");
`define PPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");
`else
`define PPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/pps_pkg.sv =====
// shared types, constants and helpers of the preemptive priority scheduler
// no dependencies
package pps_pkg;

    localparam int NPROC_DEF = 16;
    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // candidate handed from cell to cell during the scan
    typedef struct packed {
        logic        found;
        logic [7:0]  prio;
        logic [15:0] ident;
        logic [15:0] first_arr;
        logic [15:0] remaining;
        logic [31:0] ready_since;
        logic [31:0] wait_acc;
    } chain_t;

    typedef struct packed {
        logic        en;
        logic [15:0] ident;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
    } load_t;

    typedef struct packed {
        logic        en;
        logic [31:0] wait_acc;
        logic [31:0] now;
    } upd_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? SAT32 : s[31:0];
    endfunction

endpackage

// ===== rtl/core/pps_cell.sv =====
// one table slot of the scheduler: holds an entry and passes the best candidate on
// depends on pps_pkg
module pps_cell #(
    parameter int NPROC = pps_pkg::NPROC_DEF,
    parameter int SLOT  = 0,
    localparam int IW   = (NPROC > 1) ? $clog2(NPROC) : 1,
    localparam int CNTW = $clog2(NPROC + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CNTW-1:0]     count,
    input  logic [31:0]         clock_time,
    input  pps_pkg::load_t      load,
    input  pps_pkg::upd_t       upd,
    input  logic [IW-1:0]       upd_idx,
    input  pps_pkg::chain_t     chain_in,
    input  logic [IW-1:0]       idx_in,
    output pps_pkg::chain_t     chain_out,
    output logic [IW-1:0]       idx_out,
    output logic                undone
);
    import pps_pkg::*;

    logic [31:0] rs_reg;
    logic [15:0] fa_reg;
    logic [15:0] rem_reg;
    logic [7:0]  pr_reg;
    logic [15:0] id_reg;
    logic        done_reg;
    logic [31:0] wacc_reg;

    chain_t        chain_reg;
    chain_t        chain_next;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;

    logic loaded;
    logic elig;
    logic take;

    assign loaded = CNTW'(SLOT) < count;
    assign elig   = loaded && (rs_reg <= clock_time) && (rem_reg != 16'd0);
    // strict compare keeps the lower slot on a tie
    assign take   = elig && (!chain_in.found || (pr_reg < chain_in.prio));

    always_comb
    begin
        if (take)
        begin
            chain_next.found       = 1'b1;
            chain_next.prio        = pr_reg;
            chain_next.ident       = id_reg;
            chain_next.first_arr   = fa_reg;
            chain_next.remaining   = rem_reg;
            chain_next.ready_since = rs_reg;
            chain_next.wait_acc    = wacc_reg;
            idx_next               = IW'(SLOT);
        end
        else
        begin
            chain_next = chain_in;
            idx_next   = idx_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= '0;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (load.en && (count == CNTW'(SLOT)))
        begin
            rs_reg   <= {16'd0, load.arrival};
            fa_reg   <= load.arrival;
            rem_reg  <= load.burst;
            pr_reg   <= load.prio;
            id_reg   <= load.ident;
            done_reg <= (load.burst == 16'd0);
            wacc_reg <= 32'd0;
        end
        else if (upd.en && (upd_idx == IW'(SLOT)))
        begin
            rs_reg   <= upd.now;
            rem_reg  <= rem_reg - 16'd1;
            done_reg <= (rem_reg == 16'd1);
            wacc_reg <= upd.wait_acc;
        end
    end

    assign chain_out = chain_reg;
    assign idx_out   = idx_reg;
    assign undone    = loaded && !done_reg;

endmodule

// ===== rtl/core/preemptive_priority_scheduler.sv =====
// preemptive priority scheduler, top level: sequencer, totals and the row of slot cells
// depends on pps_pkg, pps_cell and preemptive_priority_scheduler_defines.svh
//
// usage:
//   input channel (in_valid/in_stall) carries one command beat: clear, load or tick.
//   clear and load give no result beat.
//   a tick beat gives exactly one result beat on the output channel
//   (out_valid/out_stall). the slot cells form a chain; the best candidate moves
//   one cell per cycle, so a tick runs a scan across all NPROC cells and then the
//   update and staging steps S_UPD1, S_UPD2 and S_FIN; the result beat is
//   registered as S_FIN ends; the next beat is taken once the sequencer is idle.
//   the input stalls while a tick is in flight; loads and clears are taken while
//   an earlier result beat still waits at the output.
//   if the receiver stalls, the result beat holds and a following tick waits in
//   its last step until the output register is free.
//   reset empties the table and clears time and totals; the entry storage itself
//   is not cleared, since only loaded slots are ever looked at.
`include "preemptive_priority_scheduler_defines.svh"
module preemptive_priority_scheduler #(
    parameter int NPROC = pps_pkg::NPROC_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [15:0] proc_id,
    input  logic [15:0] arrival,
    input  logic [15:0] burst,
    input  logic [7:0]  priority_req,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        ran,
    output logic [15:0] run_id,
    output logic        finished,
    output logic [31:0] wait_time,
    output logic [31:0] turnaround_time,
    output logic        all_done,
    output logic [31:0] now,
    output logic [31:0] total_wait,
    output logic [31:0] total_turnaround
);
    import pps_pkg::*;

    localparam int IW   = (NPROC > 1) ? $clog2(NPROC) : 1;
    localparam int CNTW = $clog2(NPROC + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_UPD1 = 2'd2;
    localparam logic [1:0] S_UPD2 = 2'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]      state_reg;
    logic [2:0]      state_next;
    logic [IW-1:0]   scan_cnt_reg;
    logic [CNTW-1:0] count_reg;
    logic [31:0]     clock_reg;
    logic [31:0]     sum_wait_reg;
    logic [31:0]     sum_turn_reg;

    chain_t          win_reg;
    logic [IW-1:0]   win_idx_reg;
    logic [31:0]     gap_reg;
    logic            fin_reg;
    logic [31:0]     w_reg;
    logic [31:0]     t_reg;

    logic            out_valid_reg;
    logic            ran_reg;
    logic [15:0]     run_id_reg;
    logic            finished_reg;
    logic [31:0]     wait_time_reg;
    logic [31:0]     turn_time_reg;
    logic            all_done_reg;
    logic [31:0]     now_reg;
    logic [31:0]     total_wait_reg;
    logic [31:0]     total_turn_reg;

    logic            in_acc;
    logic            out_acc;
    logic            out_free;
    logic            fin_go;
    logic [31:0]     sum_wait_next;
    logic [31:0]     sum_turn_next;
    logic [31:0]     w_next;
    logic [31:0]     t_next;

    load_t           load;
    upd_t            upd;
    chain_t          chain_w [NPROC+1];
    logic [IW-1:0]   idx_w   [NPROC+1];
    logic [NPROC-1:0] undone_w;

    assign in_stall = (state_reg != {1'b0, S_IDLE});
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign fin_go   = (state_reg == S_FIN) && out_free;

    assign load.en    = in_acc && (action == ACT_LOAD) && (count_reg < CNTW'(NPROC));
    assign load.ident = proc_id;
    assign load.arrival = arrival;
    assign load.burst = burst;
    assign load.prio  = priority_req;

    assign upd.en       = (state_reg == {1'b0, S_UPD2}) && win_reg.found;
    assign upd.wait_acc = w_next;
    assign upd.now      = clock_reg;

    assign chain_w[0] = '0;
    assign idx_w[0]   = '0;

    for (genvar g = 0; g < NPROC; g++)
    begin : g_cell
        pps_cell #(
            .NPROC (NPROC),
            .SLOT  (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .count      (count_reg),
            .clock_time (clock_reg),
            .load       (load),
            .upd        (upd),
            .upd_idx    (win_idx_reg),
            .chain_in   (chain_w[g]),
            .idx_in     (idx_w[g]),
            .chain_out  (chain_w[g+1]),
            .idx_out    (idx_w[g+1]),
            .undone     (undone_w[g])
        );
    end

    always_comb
    begin
        w_next = sat_add32(win_reg.wait_acc, gap_reg);
        if (clock_reg >= {16'd0, win_reg.first_arr})
        begin
            t_next = clock_reg - {16'd0, win_reg.first_arr};
        end
        else
        begin
            t_next = 32'd0;
        end
        sum_wait_next = fin_reg ? sat_add32(sum_wait_reg, w_reg) : sum_wait_reg;
        sum_turn_next = fin_reg ? sat_add32(sum_turn_reg, t_reg) : sum_turn_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            {1'b0, S_IDLE}:
            begin
                if (in_acc && (action == ACT_TICK))
                begin
                    state_next = {1'b0, S_SCAN};
                end
            end
            {1'b0, S_SCAN}:
            begin
                if (scan_cnt_reg == IW'(NPROC - 1))
                begin
                    state_next = {1'b0, S_UPD1};
                end
            end
            {1'b0, S_UPD1}:
            begin
                state_next = {1'b0, S_UPD2};
            end
            {1'b0, S_UPD2}:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = {1'b0, S_IDLE};
                end
            end
            default:
            begin
                state_next = {1'b0, S_IDLE};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= {1'b0, S_IDLE};
            scan_cnt_reg  <= '0;
            count_reg     <= '0;
            clock_reg     <= 32'd0;
            sum_wait_reg  <= 32'd0;
            sum_turn_reg  <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == {1'b0, S_SCAN})
            begin
                scan_cnt_reg <= scan_cnt_reg + IW'(1);
            end
            else
            begin
                scan_cnt_reg <= '0;
            end

            if (in_acc && (action == ACT_CLEAR))
            begin
                count_reg    <= '0;
                clock_reg    <= 32'd0;
                sum_wait_reg <= 32'd0;
                sum_turn_reg <= 32'd0;
            end
            else
            begin
                if (load.en)
                begin
                    count_reg <= count_reg + CNTW'(1);
                end
                if (state_reg == {1'b0, S_UPD1})
                begin
                    clock_reg <= (clock_reg == SAT32) ? SAT32 : clock_reg + 32'd1;
                end
                if (fin_go)
                begin
                    sum_wait_reg <= sum_wait_next;
                    sum_turn_reg <= sum_turn_next;
                end
            end

            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_acc)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // winner capture and result staging
    always_ff @(posedge clk)
    begin
        if (state_reg == {1'b0, S_UPD1})
        begin
            win_reg     <= chain_w[NPROC];
            win_idx_reg <= idx_w[NPROC];
            gap_reg     <= clock_reg - chain_w[NPROC].ready_since;
        end
        if (state_reg == {1'b0, S_UPD2})
        begin
            fin_reg <= win_reg.found && (win_reg.remaining == 16'd1);
            w_reg   <= w_next;
            t_reg   <= t_next;
        end
        if (fin_go)
        begin
            ran_reg        <= win_reg.found;
            run_id_reg     <= win_reg.found ? win_reg.ident : 16'd0;
            finished_reg   <= fin_reg;
            wait_time_reg  <= fin_reg ? w_reg : 32'd0;
            turn_time_reg  <= fin_reg ? t_reg : 32'd0;
            all_done_reg   <= ~|undone_w;
            now_reg        <= clock_reg;
            // totals ride with the beat so a clear taken during a stall leaves it intact
            total_wait_reg <= sum_wait_next;
            total_turn_reg <= sum_turn_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign ran              = ran_reg;
    assign run_id           = run_id_reg;
    assign finished         = finished_reg;
    assign wait_time        = wait_time_reg;
    assign turnaround_time  = turn_time_reg;
    assign all_done         = all_done_reg;
    assign now              = now_reg;
    assign total_wait       = total_wait_reg;
    assign total_turnaround = total_turn_reg;

    `PPS_ASSERT_NXT(a_tick_starts_scan, clk, rst_n, in_acc && (action == ACT_TICK), state_reg == {1'b0, S_SCAN})
    `PPS_ASSERT_NXT(a_fin_gives_beat, clk, rst_n, fin_go, out_valid_reg && (state_reg == {1'b0, S_IDLE}))
    `PPS_ASSERT_IMP(a_count_bounded, clk, rst_n, 1'b1, count_reg <= CNTW'(NPROC))
    `PPS_ASSERT_IMP(a_finish_needs_run, clk, rst_n, out_valid_reg, !finished_reg || ran_reg)

endmodule
